@@ rtl/csi_pkg.sv @@
// Shared types for the circle/sector intersection pipeline.
// No dependencies; used by csi_front, csi_wedge, csi_seg and the top level.
package csi_pkg;

	typedef enum logic [2:0] {
		REG_APEX_X        = 3'd0,
		REG_APEX_Y        = 3'd1,
		REG_SECTOR_RADIUS = 3'd2,
		REG_DIR_X         = 3'd3,
		REG_DIR_Y         = 3'd4,
		REG_HALF_COS      = 3'd5,
		REG_HALF_SIN      = 3'd6
	} cfg_reg_t;

	// control flags that travel with each item down the pipeline
	typedef struct packed {
		logic valid;
		logic near;   // passed the sum-of-radii distance reject
	} stage_flags_t;

endpackage

@@ rtl/csi_front.sv @@
// Stages 1-3: offsets from the apex, distance reject, edge vertex rotation.
// Depends on csi_pkg.
module csi_front #(
	parameter int CW = 24,
	parameter int TW = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [CW-1:0]            circle_x,
	input  logic signed [CW-1:0]            circle_y,
	input  logic        [CW-2:0]            circle_r,
	input  logic signed [CW-1:0]            apex_x,
	input  logic signed [CW-1:0]            apex_y,
	input  logic        [CW-2:0]            sector_radius,
	input  logic signed [TW-1:0]            dir_x,
	input  logic signed [TW-1:0]            dir_y,
	input  logic signed [TW-1:0]            half_cos,
	input  logic signed [TW-1:0]            half_sin,
	output csi_pkg::stage_flags_t           flags_s3,
	output logic signed [CW:0]              px_s3,
	output logic signed [CW:0]              py_s3,
	output logic        [2*CW+2:0]          p2_s3,
	output logic        [2*CW-3:0]          r2_s3,
	output logic signed [CW+5:0]            eax_s3,
	output logic signed [CW+5:0]            eay_s3,
	output logic signed [CW+5:0]            ebx_s3,
	output logic signed [CW+5:0]            eby_s3
);
	localparam int PW  = CW + 1;
	localparam int RU  = CW - 1;
	localparam int VW  = TW + CW;
	localparam int MW  = VW + TW;
	localparam int RW  = MW + 2;
	localparam int ROT = 2 * (TW - 2);
	localparam int P2W = 2 * PW + 1;
	localparam int R2W = 2 * RU;
	localparam logic signed [RW-1:0] HALF = {{(RW-ROT){1'b0}}, 1'b1, {(ROT-1){1'b0}}};

	// stage 1
	logic                  v_s1;
	logic signed [PW-1:0]  px_s1, py_s1;
	logic        [CW-1:0]  sum_s1;
	logic        [RU-1:0]  r_s1;
	logic signed [VW-1:0]  vx_s1, vy_s1;
	logic signed [PW-1:0]  px_d, py_d;
	logic signed [VW-1:0]  vx_d, vy_d;
	logic signed [CW-1:0]  rad_s;

	assign rad_s = $signed({1'b0, sector_radius});
	assign px_d  = PW'(circle_x) - PW'(apex_x);
	assign py_d  = PW'(circle_y) - PW'(apex_y);
	assign vx_d  = dir_x * rad_s;
	assign vy_d  = dir_y * rad_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= px_d;
			py_s1  <= py_d;
			sum_s1 <= CW'(sector_radius) + CW'(circle_r);
			r_s1   <= circle_r;
			vx_s1  <= vx_d;
			vy_s1  <= vy_d;
		end
	end

	// stage 2: squares and rotation products
	logic                   v_s2;
	logic signed [2*PW-1:0] px2_s2, py2_s2;
	logic        [2*CW-1:0] sum2_s2;
	logic        [R2W-1:0]  r2_s2;
	logic signed [MW-1:0]   vxc_s2, vys_s2, vyc_s2, vxs_s2;
	logic signed [PW-1:0]   px_s2, py_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px2_s2  <= px_s1 * px_s1;
			py2_s2  <= py_s1 * py_s1;
			sum2_s2 <= sum_s1 * sum_s1;
			r2_s2   <= r_s1 * r_s1;
			vxc_s2  <= vx_s1 * half_cos;
			vys_s2  <= vy_s1 * half_sin;
			vyc_s2  <= vy_s1 * half_cos;
			vxs_s2  <= vx_s1 * half_sin;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
		end
	end

	// stage 3: distance reject, round vertices half up to integers
	logic        [P2W-1:0] p2_d;
	logic signed [RW-1:0]  t_ax, t_ay, t_bx, t_by;

	assign p2_d = P2W'($unsigned(px2_s2)) + P2W'($unsigned(py2_s2));
	assign t_ax = RW'(vxc_s2) - RW'(vys_s2) + HALF;
	assign t_ay = RW'(vyc_s2) + RW'(vxs_s2) + HALF;
	assign t_bx = RW'(vxc_s2) + RW'(vys_s2) + HALF;
	assign t_by = RW'(vyc_s2) - RW'(vxs_s2) + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s3 <= '0;
		end else if (en) begin
			flags_s3.valid <= v_s2;
			flags_s3.near  <= p2_d <= P2W'(sum2_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			p2_s3  <= p2_d;
			r2_s3  <= r2_s2;
			eax_s3 <= t_ax[RW-1:ROT];
			eay_s3 <= t_ay[RW-1:ROT];
			ebx_s3 <= t_bx[RW-1:ROT];
			eby_s3 <= t_by[RW-1:ROT];
		end
	end

endmodule

@@ rtl/csi_wedge.sv @@
// Stages 4-5: cross and dot products of center and edge vertices.
// Depends on csi_pkg.
module csi_wedge #(
	parameter int CW = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  csi_pkg::stage_flags_t flags_s3,
	input  logic signed [CW:0]    px_s3,
	input  logic signed [CW:0]    py_s3,
	input  logic        [2*CW+2:0] p2_s3,
	input  logic        [2*CW-3:0] r2_s3,
	input  logic signed [CW+5:0]  eax_s3,
	input  logic signed [CW+5:0]  eay_s3,
	input  logic signed [CW+5:0]  ebx_s3,
	input  logic signed [CW+5:0]  eby_s3,
	output csi_pkg::stage_flags_t flags_s5,
	output logic signed [2*CW+7:0] ca_s5,
	output logic signed [2*CW+7:0] cb_s5,
	output logic signed [2*CW+12:0] ba_s5,
	output logic signed [2*CW+7:0] uaa_s5,
	output logic signed [2*CW+7:0] uab_s5,
	output logic        [2*CW+11:0] ea2_s5,
	output logic        [2*CW+11:0] eb2_s5,
	output logic        [2*CW+2:0] p2_s5,
	output logic        [2*CW-3:0] r2_s5
);
	localparam int PW  = CW + 1;
	localparam int EW  = CW + 6;
	localparam int XW  = EW + PW;
	localparam int CRW = XW + 1;
	localparam int BW  = 2 * EW + 1;
	localparam int EAW = 2 * EW;

	// stage 4: products
	csi_pkg::stage_flags_t  flags_s4;
	logic signed [XW-1:0]   ayp_s4, axp_s4, byp_s4, bxp_s4;
	logic signed [XW-1:0]   pxa_s4, pya_s4, pxb_s4, pyb_s4;
	logic signed [EAW-1:0]  aybx_s4, axby_s4;
	logic signed [EAW-1:0]  axx_s4, ayy_s4, bxx_s4, byy_s4;
	logic        [2*CW+2:0] p2_s4;
	logic        [2*CW-3:0] r2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s4 <= '0;
			flags_s5 <= '0;
		end else if (en) begin
			flags_s4 <= flags_s3;
			flags_s5 <= flags_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ayp_s4  <= eay_s3 * px_s3;
			axp_s4  <= eax_s3 * py_s3;
			byp_s4  <= eby_s3 * px_s3;
			bxp_s4  <= ebx_s3 * py_s3;
			pxa_s4  <= px_s3 * eax_s3;
			pya_s4  <= py_s3 * eay_s3;
			pxb_s4  <= px_s3 * ebx_s3;
			pyb_s4  <= py_s3 * eby_s3;
			aybx_s4 <= eay_s3 * ebx_s3;
			axby_s4 <= eax_s3 * eby_s3;
			axx_s4  <= eax_s3 * eax_s3;
			ayy_s4  <= eay_s3 * eay_s3;
			bxx_s4  <= ebx_s3 * ebx_s3;
			byy_s4  <= eby_s3 * eby_s3;
			p2_s4   <= p2_s3;
			r2_s4   <= r2_s3;
		end
	end

	// stage 5: sums; the cross term of each edge doubles as its wedge side
	always_ff @(posedge clk) begin
		if (en) begin
			ca_s5  <= CRW'(ayp_s4) - CRW'(axp_s4);
			cb_s5  <= CRW'(byp_s4) - CRW'(bxp_s4);
			ba_s5  <= BW'(aybx_s4) - BW'(axby_s4);
			uaa_s5 <= CRW'(pxa_s4) + CRW'(pya_s4);
			uab_s5 <= CRW'(pxb_s4) + CRW'(pyb_s4);
			ea2_s5 <= EAW'($unsigned(axx_s4)) + EAW'($unsigned(ayy_s4));
			eb2_s5 <= EAW'($unsigned(bxx_s4)) + EAW'($unsigned(byy_s4));
			p2_s5  <= p2_s4;
			r2_s5  <= r2_s4;
		end
	end

endmodule

@@ rtl/csi_edge.sv @@
// Stage 6 of one edge segment test, compare logic feeding stage 7.
// Depends on csi_pkg only through the parent; no package items used here.
module csi_edge #(
	parameter int CW = 24
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [2*CW+7:0] cr,
	input  logic signed [2*CW+7:0] ua,
	input  logic        [2*CW+11:0] e2,
	input  logic        [2*CW+2:0] p2,
	input  logic        [2*CW-3:0] r2,
	output logic                   edge_hit
);
	localparam int CRW = 2 * CW + 8;
	localparam int EAW = 2 * CW + 12;
	localparam int P2W = 2 * CW + 3;
	localparam int R2W = 2 * CW - 2;
	localparam int QW  = EAW + 3;
	localparam int H1  = (CRW + 1) / 2;
	localparam int G1  = CRW - H1;
	localparam int H2  = R2W / 2;
	localparam int G2  = R2W - H2;
	localparam int H3  = EAW / 2;
	localparam int G3  = EAW - H3;
	localparam int LW  = 2 * CRW;
	localparam int XW  = R2W + EAW;
	localparam int KW  = ((LW > XW) ? LW : XW) + 1;

	logic signed [QW-1:0] p2_w, e2_w, r2_w, ua_w, q2_w;
	logic                 sel_pt, sel_q, pt_ok, q_ok;
	logic        [CRW-1:0] acr;

	assign p2_w   = $signed(QW'(p2));
	assign e2_w   = $signed(QW'(e2));
	assign r2_w   = $signed(QW'(r2));
	assign ua_w   = QW'(ua);
	// squared distance to the far vertex: p^2 - 2 p.e + e^2
	assign q2_w   = p2_w + e2_w - (ua_w <<< 1);
	assign sel_pt = ua[CRW-1] || (ua == '0);
	assign sel_q  = e2_w <= ua_w;
	assign pt_ok  = p2_w <= r2_w;
	assign q_ok   = q2_w <= r2_w;
	assign acr    = cr[CRW-1] ? $unsigned(-cr) : $unsigned(cr);

	logic              simple_s6, cross_s6;
	logic [2*G1-1:0]   hh_s6;
	logic [G1+H1-1:0]  hl_s6;
	logic [2*H1-1:0]   ll_s6;
	logic [G2+G3-1:0]  rhh_s6;
	logic [G2+H3-1:0]  rhl_s6;
	logic [H2+G3-1:0]  rlh_s6;
	logic [H2+H3-1:0]  rll_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			simple_s6 <= sel_pt ? pt_ok : q_ok;
			cross_s6  <= !sel_pt && !sel_q;
			hh_s6     <= acr[CRW-1:H1] * acr[CRW-1:H1];
			hl_s6     <= acr[CRW-1:H1] * acr[H1-1:0];
			ll_s6     <= acr[H1-1:0] * acr[H1-1:0];
			rhh_s6    <= r2[R2W-1:H2] * e2[EAW-1:H3];
			rhl_s6    <= r2[R2W-1:H2] * e2[H3-1:0];
			rlh_s6    <= r2[H2-1:0] * e2[EAW-1:H3];
			rll_s6    <= r2[H2-1:0] * e2[H3-1:0];
		end
	end

	// cross^2 <= r^2 * |e|^2 replaces the perpendicular distance division
	logic [LW-1:0] lhs;
	logic [XW-1:0] rhs;

	assign lhs = (LW'(hh_s6) << (2 * H1)) + (LW'(hl_s6) << (H1 + 1)) + LW'(ll_s6);
	assign rhs = (XW'(rhh_s6) << (H2 + H3)) + (XW'(rhl_s6) << H2)
		+ (XW'(rlh_s6) << H3) + XW'(rll_s6);
	assign edge_hit = cross_s6 ? (KW'(lhs) <= KW'(rhs)) : simple_s6;

endmodule

@@ rtl/csi_seg.sv @@
// Stages 6-7: wedge decision, both edge segment tests, final result register.
// Depends on csi_pkg and csi_edge.
module csi_seg #(
	parameter int CW = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   cos_neg,
	input  csi_pkg::stage_flags_t  flags_s5,
	input  logic signed [2*CW+7:0] ca_s5,
	input  logic signed [2*CW+7:0] cb_s5,
	input  logic signed [2*CW+12:0] ba_s5,
	input  logic signed [2*CW+7:0] uaa_s5,
	input  logic signed [2*CW+7:0] uab_s5,
	input  logic        [2*CW+11:0] ea2_s5,
	input  logic        [2*CW+11:0] eb2_s5,
	input  logic        [2*CW+2:0] p2_s5,
	input  logic        [2*CW-3:0] r2_s5,
	output csi_pkg::stage_flags_t  flags_s6,
	output logic                   v_s7,
	output logic                   hit_s7
);
	localparam int CRW = 2 * CW + 8;
	localparam int BW  = 2 * CW + 13;

	logic ca_n, ca_p, cb_n, cb_p, ba_n, ba_p;
	logic inside_d, inside_s6, hit_a, hit_b;

	assign ca_n = ca_s5[CRW-1];
	assign ca_p = !ca_s5[CRW-1] && (ca_s5 != '0);
	assign cb_n = cb_s5[CRW-1];
	assign cb_p = !cb_s5[CRW-1] && (cb_s5 != '0);
	assign ba_n = ba_s5[BW-1];
	assign ba_p = !ba_s5[BW-1] && (ba_s5 != '0);

	// side of vertex a against edge b is the negated side of b against a
	always_comb begin
		if (cos_neg) begin
			inside_d = !((ca_p && ba_p) || (ca_n && ba_n))
				|| !((cb_p && ba_n) || (cb_n && ba_p));
		end else begin
			inside_d = !((ca_p && ba_n) || (ca_n && ba_p))
				&& !((cb_p && ba_p) || (cb_n && ba_n));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s6 <= '0;
			v_s7     <= 1'b0;
		end else if (en) begin
			flags_s6 <= flags_s5;
			v_s7     <= flags_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s6 <= inside_d;
			hit_s7    <= flags_s6.near && (inside_s6 || hit_a || hit_b);
		end
	end

	csi_edge #(.CW(CW)) u_edge_a (
		.clk      (clk),
		.en       (en),
		.cr       (ca_s5),
		.ua       (uaa_s5),
		.e2       (ea2_s5),
		.p2       (p2_s5),
		.r2       (r2_s5),
		.edge_hit (hit_a)
	);

	csi_edge #(.CW(CW)) u_edge_b (
		.clk      (clk),
		.en       (en),
		.cr       (cb_s5),
		.ua       (uab_s5),
		.e2       (eb2_s5),
		.p2       (p2_s5),
		.r2       (r2_s5),
		.edge_hit (hit_b)
	);

endmodule

@@ rtl/circle_sector_intersect_top.sv @@
// Circle versus sector intersection test, top level with register file.
// Depends on csi_pkg, csi_front, csi_wedge, csi_seg (and csi_edge below it).

// Takes one circle per cycle and answers 1 on hit when it touches the
// configured sector. Fully pipelined: a new transfer is taken every cycle and
// each result is computed through seven register stages set by the chain of
// multiply and sum steps (offsets, squares and rotation, rounding, cross and
// dot products, sums, split wide products, final compare). When out_ready is
// low with a result waiting, the whole pipe holds and in_ready drops. Sector
// registers are written through the cfg port, which is always ready; write
// them only while no circle is in flight.
module circle_sector_intersect_top #(
	parameter int COORD_WIDTH = 24,
	parameter int TRIG_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] circle_x,
	input  logic signed [COORD_WIDTH-1:0] circle_y,
	input  logic        [COORD_WIDTH-2:0] circle_r,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [((COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH)-1:0] cfg_data
);
	localparam int CW  = COORD_WIDTH;
	localparam int TW  = TRIG_WIDTH;
	localparam int EW  = CW + 6;
	localparam int CRW = 2 * CW + 8;
	localparam logic signed [TW-1:0] TRIG_ONE = {2'b01, {(TW-2){1'b0}}};

	logic signed [CW-1:0] apex_x_q, apex_y_q;
	logic        [CW-2:0] sector_radius_q;
	logic signed [TW-1:0] dir_x_q, dir_y_q, half_cos_q, half_sin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apex_x_q        <= '0;
			apex_y_q        <= '0;
			sector_radius_q <= '0;
			dir_x_q         <= TRIG_ONE;
			dir_y_q         <= '0;
			half_cos_q      <= TRIG_ONE;
			half_sin_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (csi_pkg::cfg_reg_t'(cfg_index))
				csi_pkg::REG_APEX_X:        apex_x_q        <= cfg_data[CW-1:0];
				csi_pkg::REG_APEX_Y:        apex_y_q        <= cfg_data[CW-1:0];
				csi_pkg::REG_SECTOR_RADIUS: sector_radius_q <= cfg_data[CW-2:0];
				csi_pkg::REG_DIR_X:         dir_x_q         <= cfg_data[TW-1:0];
				csi_pkg::REG_DIR_Y:         dir_y_q         <= cfg_data[TW-1:0];
				csi_pkg::REG_HALF_COS:      half_cos_q      <= cfg_data[TW-1:0];
				csi_pkg::REG_HALF_SIN:      half_sin_q      <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// single pipeline enable: everything advances unless a result is held
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	csi_pkg::stage_flags_t flags_s3, flags_s5, flags_s6;
	logic signed [CW:0]      px_s3, py_s3;
	logic        [2*CW+2:0]  p2_s3, p2_s5;
	logic        [2*CW-3:0]  r2_s3, r2_s5;
	logic signed [EW-1:0]    eax_s3, eay_s3, ebx_s3, eby_s3;
	logic signed [CRW-1:0]   ca_s5, cb_s5, uaa_s5, uab_s5;
	logic signed [2*EW:0]    ba_s5;
	logic        [2*EW-1:0]  ea2_s5, eb2_s5;

	csi_front #(.CW(CW), .TW(TW)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.circle_x      (circle_x),
		.circle_y      (circle_y),
		.circle_r      (circle_r),
		.apex_x        (apex_x_q),
		.apex_y        (apex_y_q),
		.sector_radius (sector_radius_q),
		.dir_x         (dir_x_q),
		.dir_y         (dir_y_q),
		.half_cos      (half_cos_q),
		.half_sin      (half_sin_q),
		.flags_s3      (flags_s3),
		.px_s3         (px_s3),
		.py_s3         (py_s3),
		.p2_s3         (p2_s3),
		.r2_s3         (r2_s3),
		.eax_s3        (eax_s3),
		.eay_s3        (eay_s3),
		.ebx_s3        (ebx_s3),
		.eby_s3        (eby_s3)
	);

	csi_wedge #(.CW(CW)) u_wedge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.flags_s3 (flags_s3),
		.px_s3    (px_s3),
		.py_s3    (py_s3),
		.p2_s3    (p2_s3),
		.r2_s3    (r2_s3),
		.eax_s3   (eax_s3),
		.eay_s3   (eay_s3),
		.ebx_s3   (ebx_s3),
		.eby_s3   (eby_s3),
		.flags_s5 (flags_s5),
		.ca_s5    (ca_s5),
		.cb_s5    (cb_s5),
		.ba_s5    (ba_s5),
		.uaa_s5   (uaa_s5),
		.uab_s5   (uab_s5),
		.ea2_s5   (ea2_s5),
		.eb2_s5   (eb2_s5),
		.p2_s5    (p2_s5),
		.r2_s5    (r2_s5)
	);

	csi_seg #(.CW(CW)) u_seg (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cos_neg  (half_cos_q[TW-1]),
		.flags_s5 (flags_s5),
		.ca_s5    (ca_s5),
		.cb_s5    (cb_s5),
		.ba_s5    (ba_s5),
		.uaa_s5   (uaa_s5),
		.uab_s5   (uab_s5),
		.ea2_s5   (ea2_s5),
		.eb2_s5   (eb2_s5),
		.p2_s5    (p2_s5),
		.r2_s5    (r2_s5),
		.flags_s6 (flags_s6),
		.v_s7     (out_valid),
		.hit_s7   (hit)
	);

	// a held result blocks new input transfers
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// a circle beyond the sum of radii always reports a miss
	a_far_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		en && flags_s6.valid && !flags_s6.near |=> out_valid && !hit)
		else $error("distance reject not honored");

	// no result appears unless an item sat in stage 6
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		en && !flags_s6.valid |=> !out_valid)
		else $error("result without an item");

endmodule
